// ===== rtl/sts_pkg.sv =====
// package for the multichannel timed step sequencer
// holds the channel entry type, opcodes, state codes and sizing constants
// no dependencies
package sts_pkg;

   // default number of channel entries in the state memory
   localparam int STS_CHANNELS = 32;

   // field widths fixed by the item format
   localparam int OPCODE_W  = 2;
   localparam int CHANNEL_W = 5;
   localparam int TIME_W    = 32;
   localparam int STEP_W    = 16;
   localparam int COUNT_W   = 6;

   // item opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_PASS    = 2'd0,
      OP_AT      = 2'd1,
      OP_BETWEEN = 2'd2
   } op_type;

   // control states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // one channel's state, stored as one memory word
   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] acc_wait;
      logic [STEP_W-1:0] wait_step;
      logic [STEP_W-1:0] cur_step;
   } entry_type;

endpackage

// ===== rtl/sts_state_mem.sv =====
// channel state memory: one write port, one read port, registered read data
// entries read as zero until first written; same-entry read and write forwards
// depends on sts_pkg
module sts_state_mem #(
   parameter int CHANNELS = sts_pkg::STS_CHANNELS,
   parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output sts_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  sts_pkg::entry_type  wr_data
);
   import sts_pkg::*;

   entry_type               mem [CHANNELS];
   logic [CHANNELS-1:0]     valid_ff;
   entry_type               mem_q_ff;
   logic                    mem_vld_ff;
   entry_type               byp_ff;
   logic                    byp_hit_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // written marks, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read with write forwarding
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr];
         mem_vld_ff <= valid_ff[rd_addr];
         byp_ff     <= wr_data;
         byp_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   // unwritten entries read as the reset value
   always_comb begin
      if (byp_hit_ff) begin
         rd_data = byp_ff;
      end else if (mem_vld_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ===== rtl/sts_step_alu.sv =====
// per-channel update: pass-start rewind, at step and between-window step
// works on one channel entry read from the state memory
// depends on sts_pkg
module sts_step_alu (
   input  logic [1:0]          opcode,
   input  logic [31:0]         offset_us,
   input  logic [31:0]         duration_us,
   input  logic [31:0]         now_us,
   input  sts_pkg::entry_type  entry_old,
   output sts_pkg::entry_type  entry_new,
   output logic                fire
);
   import sts_pkg::*;

   logic              on_wait;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] win_start;
   logic [TIME_W-1:0] win_end;
   logic              past_start;
   logic              past_end;

   // time arithmetic, all modulo 2^32
   always_comb begin
      on_wait    = (entry_old.wait_step == entry_old.cur_step);
      elapsed    = now_us - entry_old.start_time;
      win_start  = entry_old.acc_wait + offset_us;
      win_end    = win_start + duration_us;
      past_start = (elapsed >= win_start);
      past_end   = (elapsed >= win_end);
   end

   // entry update per opcode
   always_comb begin
      entry_new = entry_old;
      fire      = 1'b0;
      unique case (opcode)
         OP_PASS: begin
            if (on_wait) begin
               entry_new.start_time = now_us;
               entry_new.acc_wait   = '0;
               entry_new.wait_step  = '0;
            end
            entry_new.cur_step = '0;
         end
         OP_AT: begin
            if (on_wait && past_start) begin
               fire                = 1'b1;
               entry_new.acc_wait  = win_start;
               entry_new.wait_step = entry_old.wait_step + 1'b1;
            end
            entry_new.cur_step = entry_old.cur_step + 1'b1;
         end
         OP_BETWEEN: begin
            fire = on_wait && past_start && !past_end;
            if (on_wait && past_end) begin
               entry_new.wait_step = entry_old.wait_step + 1'b1;
            end
            entry_new.cur_step = entry_old.cur_step + 1'b1;
         end
         default: begin
            entry_new = entry_old;
         end
      endcase
   end

endmodule

// ===== rtl/multichannel_timed_step_sequencer.sv =====
// Step item: the channel's entry is read from the state memory on acceptance, then
// updated and written back in the execute state; the result strobe is registered.
// Pass start walks n = min(channel_count, CHANNELS) entries, one entry per cycle.
// A new item may be accepted in the cycle its predecessor's result is strobed.
// Synchronous active-high reset clears control, channel_count and all channel entries
// (entries read as zero until written); no clearing pass. Results cannot be stalled.
module multichannel_timed_step_sequencer #(
   parameter int CHANNELS = sts_pkg::STS_CHANNELS,
   parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic        clock,
   input  logic        reset,
   // item command port
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_channel,
   input  logic [31:0] req_offset_us,
   input  logic [31:0] req_duration_us,
   input  logic [31:0] req_now_us,
   // result strobe
   output logic        rsp_valid,
   output logic        rsp_fire,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_channel_count
);
   import sts_pkg::*;

   state_type          state_ff, state_in;
   logic [5:0]         count_ff;
   logic [1:0]         op_ff;
   logic               ch_ok_ff;
   logic [31:0]        offset_ff;
   logic [31:0]        duration_ff;
   logic [31:0]        now_ff;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic               empty_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fire_ff, rsp_fire_in;

   logic               accept;
   logic               done;
   logic               req_ch_ok;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   entry_type          rd_data;
   entry_type          wr_data;
   logic               alu_fire;

   // channel range and last pass index
   always_comb begin
      req_ch_ok = (int'(req_channel) < CHANNELS);
      if (int'(count_ff) >= CHANNELS) begin
         last_in = IDX_W'(CHANNELS - 1);
      end else begin
         last_in = IDX_W'(count_ff - 6'd1);
      end
   end

   // sequencer next state and memory control
   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      done     = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      addr_in  = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               accept   = 1'b1;
               state_in = ST_EXEC;
               if (req_opcode == OP_PASS) begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
                  addr_in = '0;
               end else begin
                  rd_en   = req_ch_ok;
                  rd_addr = IDX_W'(req_channel);
                  addr_in = IDX_W'(req_channel);
               end
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_PASS) begin
               wr_en   = !empty_ff;
               done    = empty_ff || (addr_ff == last_ff);
               rd_en   = !done;
               rd_addr = addr_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
            end else begin
               wr_en = ch_ok_ff && ((op_ff == OP_AT) || (op_ff == OP_BETWEEN));
               done  = 1'b1;
            end
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = done;
      rsp_fire_in  = done && wr_en && alu_fire;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_fire_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_fire_ff  <= rsp_fire_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_channel_count;
         end
      end
   end

   // item payload and walk index
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (accept) begin
         op_ff       <= req_opcode;
         ch_ok_ff    <= req_ch_ok;
         offset_ff   <= req_offset_us;
         duration_ff <= req_duration_us;
         now_ff      <= req_now_us;
         last_ff     <= last_in;
         empty_ff    <= (count_ff == 6'd0);
      end
   end

   sts_state_mem #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (addr_ff),
      .wr_data  (wr_data)
   );

   sts_step_alu u_alu (
      .opcode      (op_ff),
      .offset_us   (offset_ff),
      .duration_us (duration_ff),
      .now_us      (now_ff),
      .entry_old   (rd_data),
      .entry_new   (wr_data),
      .fire        (alu_fire)
   );

   // ports
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_fire  = rsp_fire_ff;

endmodule

// ===== rtl/sts_checker.sv =====
// port-level checks for the multichannel timed step sequencer
// bound to the top level; no package dependency
module sts_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_fire
);

   // an accepted beat always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // a result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   // a result arrives when the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   // every item passes through the execute state before its result, so strobes never touch
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // fire only with a result
   a_fire_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_valid)
      else $error("fire outside a result beat");

endmodule

bind multichannel_timed_step_sequencer sts_checker u_sts_checker (.*);
